// ===== rtl/core/rpr_pkg.sv =====
// Shared package of the rotary position rotator: formats, constants, the
// arctangent table and the build-time frequency table generator.
// No dependencies.
package rpr_pkg;

    localparam int DATA_W      = 16;
    localparam int POS_W       = 12;
    localparam int PAIR_W      = 5;
    localparam int PAIR_COUNT  = 1 << PAIR_W;
    localparam int PHASE_W     = 32;
    localparam int SCALE_W     = 32;                 // pre-scaled Q.16 value
    localparam int XY_W        = 36;                 // CORDIC datapath, headroom for gain
    localparam int Z_W         = 34;
    localparam int GUARD       = 16;
    localparam int SAT_BITS    = 16;
    localparam int MAX_POSITION_DEF = 4096;
    localparam int EMBED_DIM_DEF    = 64;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
    localparam logic [63:0] L2T      = 64'd57070290109;
    localparam logic [63:0] L2PI     = 64'd11388089162;
    localparam logic [63:0] LN2_Q32  = 64'd2977044472;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef logic [PHASE_W-1:0] t_freq_tab [PAIR_COUNT];

    // Work item handed from the front to the back through the queue.
    typedef struct packed {
        logic [PHASE_W-1:0]        phase;
        logic signed [SCALE_W-1:0] x;
        logic signed [SCALE_W-1:0] y;
    } t_work;

    // 2^-g in Q.32 for g in Q0.32: truncated Taylor series of exp(-g*ln2).
    function automatic logic [63:0] pow2neg(input logic [31:0] g);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = ({32'd0, g} * LN2_Q32) >> 32;
        term = 64'd1 << 32;
        sum  = term;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * x) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Rotation frequency in turns per position, Q0.32.
    function automatic logic [31:0] pair_freq(input int pair, input int dim_total);
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] v;
        e = (64'd2 * 64'(pair) * L2T) / 64'(dim_total) + L2PI;
        n = e >> 32;
        v = pow2neg(e[31:0]);
        if (n >= 64'd63) begin
            return 32'd0;
        end
        v = v >> n;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic t_freq_tab build_freq_tab(input int dim_total);
        t_freq_tab tab;
        for (int p = 0; p < PAIR_COUNT; p++) begin
            tab[p] = pair_freq(p, dim_total);
        end
        return tab;
    endfunction

endpackage

// ===== rtl/core/rpr_front.sv =====
// Front end: accepts items, clamps position, looks up the frequency, forms
// the phase and the gain-compensated vector. Depends on rpr_pkg.
module rpr_front #(
    parameter int EMBED_DIM    = rpr_pkg::EMBED_DIM_DEF,
    parameter int MAX_POSITION = rpr_pkg::MAX_POSITION_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_q_value,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_k_value,
    input  logic [rpr_pkg::POS_W-1:0]         i_position,
    input  logic [rpr_pkg::PAIR_W-1:0]        i_pair_index,
    output logic                              o_work_valid,
    output rpr_pkg::t_work                    o_work,
    input  logic                              i_queue_full
);
    import rpr_pkg::*;

    localparam t_freq_tab FREQ_TAB = build_freq_tab(EMBED_DIM);
    localparam logic [16:0] POS_LIMIT = 17'(MAX_POSITION - 1);

    logic                       w_en;
    logic                       w_clamp;
    logic                       r_f1_v;
    logic signed [DATA_W-1:0]   r_q;
    logic signed [DATA_W-1:0]   r_k;
    logic [POS_W-1:0]           r_pos;
    logic [PHASE_W-1:0]         r_freq;
    logic                       r_f2_v;
    t_work                      r_work;
    logic [POS_W+PHASE_W-1:0]   w_phase_full;
    logic signed [48:0]         w_q_scaled;
    logic signed [48:0]         w_k_scaled;

    // hold both stages while the queue cannot take the finished item
    assign w_en    = !(r_f2_v && i_queue_full);
    assign o_full  = !w_en;
    assign w_clamp = {5'd0, i_position} > POS_LIMIT;

    assign w_phase_full = {{POS_W{1'b0}}, r_freq} * {{PHASE_W{1'b0}}, r_pos};
    assign w_q_scaled   = 49'(r_q) * $signed({17'd0, INV_GAIN});
    assign w_k_scaled   = 49'(r_k) * $signed({17'd0, INV_GAIN});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_push;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q    <= i_q_value;
            r_k    <= i_k_value;
            r_pos  <= w_clamp ? POS_LIMIT[POS_W-1:0] : i_position;
            r_freq <= FREQ_TAB[i_pair_index];
            r_work.phase <= w_phase_full[PHASE_W-1:0];
            r_work.x     <= w_q_scaled[GUARD+SCALE_W-1:GUARD];
            r_work.y     <= w_k_scaled[GUARD+SCALE_W-1:GUARD];
        end
    end

    assign o_work_valid = r_f2_v;
    assign o_work       = r_work;

endmodule

// ===== rtl/core/rpr_queue.sv =====
// Short queue of work items between front and back.
// Depends on rpr_pkg.
module rpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rpr_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rpr_pkg::t_work o_head,
    output logic           o_empty
);
    import rpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_work               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr;
    logic [PTR_W-1:0]    r_rd;
    logic [PTR_W:0]      r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = r_count == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== rtl/core/rpr_back.sv =====
// Back end: quadrant fold, pipelined CORDIC rotation, rounding and
// saturation into the result register. Depends on rpr_pkg.
module rpr_back #(
    parameter int CORDIC_STEPS = rpr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rpr_pkg::t_work                     i_head,
    input  logic                               i_head_empty,
    output logic                               o_head_pop,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [rpr_pkg::DATA_W-1:0]  o_q_rotated,
    output logic signed [rpr_pkg::DATA_W-1:0]  o_k_rotated
);
    import rpr_pkg::*;

    localparam int N = CORDIC_STEPS;
    localparam int RND_W = XY_W - GUARD;

    logic                    w_en;
    logic                    w_flip;
    logic [N+1:0]            r_v;
    logic signed [XY_W-1:0]  r_x [N+1];
    logic signed [XY_W-1:0]  r_y [N+1];
    logic signed [Z_W-1:0]   r_z [N+1];
    logic signed [XY_W-1:0]  w_x0;
    logic signed [XY_W-1:0]  w_y0;
    logic [PHASE_W-1:0]      w_ph0;
    logic signed [XY_W-1:0]  w_xr;
    logic signed [XY_W-1:0]  w_yr;
    logic signed [DATA_W-1:0] r_q_out;
    logic signed [DATA_W-1:0] r_k_out;

    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [XY_W-1:0] v);
        logic signed [RND_W-1:0] r;
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = RND_W'((1 << (SAT_BITS - 1)) - 1);
        lo = -hi - RND_W'(1);
        r  = RND_W'(v >>> GUARD);
        if (r > hi) begin
            return hi[DATA_W-1:0];
        end else if (r < lo) begin
            return lo[DATA_W-1:0];
        end
        return r[DATA_W-1:0];
    endfunction

    // advance the whole pipe unless the result waits untaken
    assign w_en       = !r_v[N+1] || i_pop;
    assign o_head_pop = w_en && !i_head_empty;

    // fold phases in [1/4, 3/4) turn by negating the vector
    assign w_flip = i_head.phase[31] ^ i_head.phase[30];
    assign w_x0   = w_flip ? -XY_W'(i_head.x) : XY_W'(i_head.x);
    assign w_y0   = w_flip ? -XY_W'(i_head.y) : XY_W'(i_head.y);
    assign w_ph0  = {i_head.phase[31] ^ w_flip, i_head.phase[30:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[N:0], !i_head_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= w_x0;
            r_y[0] <= w_y0;
            r_z[0] <= Z_W'($signed(w_ph0));
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_TURNS[i]);
        logic signed [XY_W-1:0] w_xs;
        logic signed [XY_W-1:0] w_ys;
        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + ATAN;
                end
            end
        end
    end

    assign w_xr = r_x[N] + XY_W'(1 << (GUARD - 1));
    assign w_yr = r_y[N] + XY_W'(1 << (GUARD - 1));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_out <= round_sat(w_xr);
            r_k_out <= round_sat(w_yr);
        end
    end

    assign o_empty     = !r_v[N+1];
    assign o_q_rotated = r_q_out;
    assign o_k_rotated = r_k_out;

endmodule

// ===== rtl/core/rotary_position_rotator_unit.sv =====
// Rotary position rotator: rotates a (q, k) pair by position * frequency.
// Path from accept to result: two front stages (the first loads at the
// accepting edge), the queue, the fold register, one stage per CORDIC step
// and the result register. Throughput: one item per cycle while results
// are popped, one pipelined CORDIC stage per step.
// Reset (synchronous, active low) empties all stages.
module rotary_position_rotator_unit #(
    parameter int EMBED_DIM    = rpr_pkg::EMBED_DIM_DEF,
    parameter int MAX_POSITION = rpr_pkg::MAX_POSITION_DEF,
    parameter int CORDIC_STEPS = rpr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_q_value,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_k_value,
    input  logic [rpr_pkg::POS_W-1:0]         i_position,
    input  logic [rpr_pkg::PAIR_W-1:0]        i_pair_index,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rpr_pkg::DATA_W-1:0] o_q_rotated,
    output logic signed [rpr_pkg::DATA_W-1:0] o_k_rotated
);
    import rpr_pkg::*;

    logic  w_work_valid;
    t_work w_work;
    logic  w_queue_full;
    t_work w_head;
    logic  w_head_empty;
    logic  w_head_pop;

    rpr_front #(
        .EMBED_DIM    (EMBED_DIM),
        .MAX_POSITION (MAX_POSITION)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_q_value    (i_q_value),
        .i_k_value    (i_k_value),
        .i_position   (i_position),
        .i_pair_index (i_pair_index),
        .o_work_valid (w_work_valid),
        .o_work       (w_work),
        .i_queue_full (w_queue_full)
    );

    rpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_work_valid),
        .i_data  (w_work),
        .o_full  (w_queue_full),
        .i_pop   (w_head_pop),
        .o_head  (w_head),
        .o_empty (w_head_empty)
    );

    rpr_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_empty (w_head_empty),
        .o_head_pop   (w_head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_q_rotated  (o_q_rotated),
        .o_k_rotated  (o_k_rotated)
    );

endmodule

// ===== rtl/core/rpr_checker.sv =====
// Port-level checks of the rotary position rotator, bound to the top level.
// Depends on rotary_position_rotator_unit.
module rpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_q_rotated,
    input logic [15:0] o_k_rotated
);

    // reset leaves nothing in flight
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not empty or full after reset");

    // a waiting result stays put until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_q_rotated) && $stable(o_k_rotated)))
        else $error("result changed while waiting");

    // the input side backs up only behind a stalled result
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(!empty && !pop))
        else $error("full rose without output stall");

endmodule

bind rotary_position_rotator_unit rpr_checker u_rpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_q_rotated (o_q_rotated),
    .o_k_rotated (o_k_rotated)
);

// ===== dv/rotary_position_rotator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the rotary position rotator: directed table plus random pairs.
// Needs rpr_pkg and rotary_position_rotator_unit; predicts each rotated pair on its own.
module rotary_position_rotator_unit_test;
    import rpr_pkg::*;

    localparam int STEPS      = CORDIC_STEPS_DEF;
    localparam int EMBED      = EMBED_DIM_DEF;
    localparam int RANDOM_N   = 400;
    localparam int TAIL       = 40;
    localparam int LIMIT      = 400000;
    localparam longint INVK   = longint'(INV_GAIN);
    localparam longint SAT_HI = 32767;
    localparam longint SAT_LO = -32768;

    typedef struct {
        logic signed [DATA_W-1:0] q;
        logic signed [DATA_W-1:0] k;
        logic [POS_W-1:0]         pos;
        logic [PAIR_W-1:0]        pair;
        bit                       typed;   // expected result written in the table
        logic signed [DATA_W-1:0] eq;
        logic signed [DATA_W-1:0] ek;
        bit                       drain;   // hold off until the pipe is empty
    } t_pair_beat;

    typedef struct {
        logic signed [DATA_W-1:0] q;
        logic signed [DATA_W-1:0] k;
    } t_rot_pair;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_push;
    logic                     full;
    logic signed [DATA_W-1:0] i_q_value;
    logic signed [DATA_W-1:0] i_k_value;
    logic [POS_W-1:0]         i_position;
    logic [PAIR_W-1:0]        i_pair_index;
    logic                     empty;
    logic                     i_pop;
    logic signed [DATA_W-1:0] o_q_rotated;
    logic signed [DATA_W-1:0] o_k_rotated;

    t_pair_beat beats[$];
    t_rot_pair  rotated_q[$];
    int         next_beat;
    int         errors;
    int         checked;
    int         cycles;
    int         tail_cnt;
    int         rst_cnt;
    bit         done;

    rotary_position_rotator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (i_push),
        .full        (full),
        .i_q_value   (i_q_value),
        .i_k_value   (i_k_value),
        .i_position  (i_position),
        .i_pair_index(i_pair_index),
        .empty       (empty),
        .pop         (i_pop),
        .o_q_rotated (o_q_rotated),
        .o_k_rotated (o_k_rotated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // 2^-g in Q.32 by a truncated exp(-g*ln2) series
    function automatic longint unsigned exp2_frac(input logic [31:0] g);
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        x    = (longint'(g) * longint'(LN2_Q32)) >> 32;
        term = 64'd1 << 32;
        acc  = term;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * x) >> 32) / longint'(n);
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // turns per position, Q0.32
    function automatic logic [31:0] turn_rate(input logic [PAIR_W-1:0] pair);
        longint unsigned e;
        longint unsigned ipart;
        longint unsigned v;
        e     = (64'd2 * longint'(pair) * L2T) / longint'(EMBED) + L2PI;
        ipart = e >> 32;
        v     = exp2_frac(e[31:0]);
        if (ipart >= 63) begin
            return 32'd0;
        end
        v = v >> ipart;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] round_sat(input longint v);
        longint r;
        r = (v + (longint'(1) << (GUARD - 1))) >>> GUARD;
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        return r[DATA_W-1:0];
    endfunction

    function automatic t_rot_pair rotate_pair(input t_pair_beat b);
        logic [POS_W-1:0] pos;
        logic [31:0]      phase;
        longint           x;
        longint           y;
        longint           z;
        longint           nx;
        longint           ny;
        t_rot_pair        r;
        pos = b.pos;
        if (longint'(pos) > MAX_POSITION_DEF - 1) pos = POS_W'(MAX_POSITION_DEF - 1);
        phase = 32'(longint'(pos) * longint'(turn_rate(b.pair)));
        x = (longint'(b.q) * INVK) >>> (32 - GUARD);
        y = (longint'(b.k) * INVK) >>> (32 - GUARD);
        // fold the back half turn onto the front
        if (phase >= 32'h4000_0000 && phase < 32'hC000_0000) begin
            x = -x;
            y = -y;
            phase = phase - 32'h8000_0000;
        end
        z = longint'($signed(phase));
        for (int i = 0; i < STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(ATAN_TURNS[i]);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
            y = ny;
        end
        r.q = round_sat(x);
        r.k = round_sat(y);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at beat %0d: %s got %0d expected %0d", checked, what, got, want);
        errors++;
    endtask

    function automatic void add_beat(input int q, input int k, input int pos, input int pair,
                                     input bit typed, input int eq, input int ek);
        t_pair_beat b;
        b.q = DATA_W'(q); b.k = DATA_W'(k); b.pos = POS_W'(pos); b.pair = PAIR_W'(pair);
        b.typed = typed; b.eq = DATA_W'(eq); b.ek = DATA_W'(ek); b.drain = 1'b0;
        beats.insert(beats.size(), b);
    endfunction

    // idle pattern by stretch of the run: none, sender, receiver, both
    function automatic int idle_mode();
        return (next_beat / 50) % 4;
    endfunction

    // one process drives both sides and checks, so the two never race
    always @(posedge i_clk) begin
        t_pair_beat b;
        t_rot_pair  want;
        int         mode;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL rotary_position_rotator_unit");
            $finish;
        end else if (rst_cnt < 3) begin
            rst_cnt <= rst_cnt + 1;
            i_rst_n <= (rst_cnt == 2);
        end else begin
            if (i_pop && !empty) begin
                if (rotated_q.size() == 0) begin
                    report_mismatch("unexpected beat, q", o_q_rotated, 0);
                end else begin
                    want = rotated_q.pop_front();
                    if (o_q_rotated !== want.q) report_mismatch("q_rotated", o_q_rotated, want.q);
                    if (o_k_rotated !== want.k) report_mismatch("k_rotated", o_k_rotated, want.k);
                end
                checked++;
            end
            if (i_push && !full) begin
                b = beats[next_beat];
                if (b.typed) begin
                    want.q = b.eq;
                    want.k = b.ek;
                end else begin
                    want = rotate_pair(b);
                end
                rotated_q.insert(rotated_q.size(), want);
                next_beat++;
            end
            mode = idle_mode();
            if (next_beat < beats.size()
                    && !((mode == 1 || mode == 3) && $urandom_range(99) < (mode == 1 ? 54 : 33))
                    && !(beats[next_beat].drain && rotated_q.size() != 0)) begin
                b = beats[next_beat];
                i_push       <= 1'b1;
                i_q_value    <= b.q;
                i_k_value    <= b.k;
                i_position   <= b.pos;
                i_pair_index <= b.pair;
            end else begin
                i_push <= 1'b0;
            end
            i_pop <= !((mode == 2 || mode == 3) && $urandom_range(99) < (mode == 2 ? 54 : 33));
            if (next_beat == beats.size() && rotated_q.size() == 0) begin
                tail_cnt <= tail_cnt + 1;
                if (tail_cnt >= TAIL) done <= 1'b1;
            end
        end
    end

    initial begin
        int q;
        int k;
        i_rst_n = 1'b0; i_push = 1'b0; i_pop = 1'b0;
        i_q_value = '0; i_k_value = '0; i_position = '0; i_pair_index = '0;
        errors = 0; checked = 0; cycles = 0; next_beat = 0; tail_cnt = 0; rst_cnt = 0;
        done = 1'b0;
        // zero vector stays zero at any angle
        add_beat(0, 0, 0, 0, 1'b1, 0, 0);
        add_beat(0, 0, 4095, 31, 1'b1, 0, 0);
        add_beat(0, 0, 1234, 7, 1'b1, 0, 0);
        add_beat(32767, 32767, 0, 0, 1'b0, 0, 0);
        add_beat(-32768, -32768, 0, 0, 1'b0, 0, 0);
        add_beat(32767, -32768, 4095, 0, 1'b0, 0, 0);
        add_beat(-32768, 32767, 4095, 31, 1'b0, 0, 0);
        add_beat(4096, 0, 1, 0, 1'b0, 0, 0);
        add_beat(0, 4096, 1, 0, 1'b0, 0, 0);
        add_beat(4096, 4096, 2, 0, 1'b0, 0, 0);
        add_beat(-4096, 4096, 3, 0, 1'b0, 0, 0);
        add_beat(32767, 32767, 4095, 1, 1'b0, 0, 0);
        // pair indexes near and past half the embedding: slow rotations
        add_beat(12345, -2345, 4095, 16, 1'b0, 0, 0);
        add_beat(-12345, 2345, 4095, 24, 1'b0, 0, 0);
        add_beat(21000, 21000, 4095, 31, 1'b0, 0, 0);
        add_beat(-21000, 1, 2048, 30, 1'b0, 0, 0);
        add_beat(1, -1, 4095, 15, 1'b0, 0, 0);
        add_beat(-1, 1, 1, 31, 1'b0, 0, 0);
        beats[beats.size()-1].drain = 1'b1;
        for (int n = 0; n < RANDOM_N; n++) begin
            q = $urandom_range(9) == 0 ? ($urandom_range(1) ? 32767 : -32768)
                                       : int'($signed(16'($urandom)));
            k = $urandom_range(9) == 0 ? ($urandom_range(1) ? 32767 : -32768)
                                       : int'($signed(16'($urandom)));
            add_beat(q, k, $urandom_range(7) == 0 ? ($urandom_range(1) ? 4095 : 0)
                                                  : $urandom_range(4095),
                     $urandom_range(31), 1'b0, 0, 0);
        end
        beats[beats.size()/2].drain = 1'b1;
        wait (done);
        $display("covered %0d pairs (directed extremes and %0d random) under four idle patterns",
                 beats.size(), RANDOM_N);
        if (rotated_q.size() != 0) begin
            $display("%0d expected beats never arrived", rotated_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS rotary_position_rotator_unit");
        end else begin
            $display("FAIL rotary_position_rotator_unit");
        end
        $finish;
    end

endmodule
